[sv/ptrs_pkg.sv]
// patch table record streamer: shared types, codes, constants and lookup functions
// no dependencies; used by the configuration interface and the top level
`default_nettype none

package ptrs_pkg;

   localparam int TAG_BYTES      = 16;
   localparam int TAG_CHECKED    = 13;
   localparam int HEADER_BYTES   = 24;
   localparam int HDR_TYPE_LAST  = 19;
   localparam int HDR_BYTE_BITS  = 5;
   localparam int MODE_PAIRS     = 9;
   localparam int INFO_PAIRS     = 2;
   localparam int PAIR_NUM_BITS  = 4;
   localparam int PAIR_BYTE_BITS = 3;
   localparam int PAIR_ADDR_LAST = 3;
   localparam int PAIR_LAST      = 7;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [31:0] TYPE_INFO     = 32'd0;
   localparam logic [31:0] TYPE_MODE     = 32'd3;
   localparam logic [31:0] TYPE_VERSION  = 32'd6;
   localparam logic [31:0] TYPE_NO_PAIRS = 32'd1000;

   localparam logic CMD_BYTE   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_APPLY_MODE   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_LENGTH = 1'b1;

   typedef enum logic [2:0] {
      PH_TAG    = 3'b001,
      PH_HEADER = 3'b010,
      PH_PAIRS  = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      CL_PLAIN      = 3'd0,
      CL_INFO_FIRST = 3'd1,
      CL_INFO_LATER = 3'd2,
      CL_MODE       = 3'd3,
      CL_VERSION    = 3'd4,
      CL_HIGH       = 3'd5
   } record_class_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [31:0] value;
      logic        status;
   } result_type;

   // expected tag text, terminated by a zero byte
   function automatic logic [7:0] tag_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h41;
         4'd1:    c = 8'h49;
         4'd2:    c = 8'h43;
         4'd3:    c = 8'h42;
         4'd4:    c = 8'h54;
         4'd5:    c = 8'h5f;
         4'd6:    c = 8'h50;
         4'd7:    c = 8'h54;
         4'd8:    c = 8'h5f;
         4'd9:    c = 8'h54;
         4'd10:   c = 8'h41;
         4'd11:   c = 8'h47;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // fixed values substituted for the first pairs of a mode record
   function automatic logic [31:0] mode_value(input logic [PAIR_NUM_BITS-1:0] idx);
      logic [31:0] v;
      case (idx)
         4'd0:    v = 32'd1;
         4'd1:    v = 32'hffff_ffff;
         4'd2:    v = 32'd0;
         4'd3:    v = 32'd5;
         4'd4:    v = 32'd2;
         4'd5:    v = 32'd1500000;
         4'd6:    v = 32'd1;
         4'd7:    v = 32'd1;
         4'd8:    v = 32'h0000_6f2f;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[sv/ptrs_req_if.sv]
// input channel: table bytes and finish commands
// depends on nothing but plain logic types
`default_nettype none

interface ptrs_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] table_byte;

   modport source (output valid, output cmd, output table_byte, input ready);
   modport sink   (input valid, input cmd, input table_byte, output ready);
endinterface

`default_nettype wire

[sv/ptrs_rsp_if.sv]
// result channel: memory writes and finish reports
// depends on nothing but plain logic types
`default_nettype none

interface ptrs_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] address;
   logic [31:0] value;
   logic        status;

   modport source (output valid, output kind, output address, output value,
                   output status, input ready);
   modport sink   (input valid, input kind, input address, input value,
                   input status, output ready);
endinterface

`default_nettype wire

[sv/ptrs_csr_if.sv]
// configuration write channel: register index and write data
// uses ptrs_pkg for the index width
`default_nettype none

interface ptrs_csr_if #(
   parameter int DATA_BITS = 20
);
   logic                                valid;
   logic                                ready;
   logic [ptrs_pkg::CSR_INDEX_BITS-1:0] index;
   logic [DATA_BITS-1:0]                data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/patch_table_record_streamer_unit.sv]
// Patch table record streamer. Parses a patch table one byte per transaction.
// Channels: req_ch carries a command and a table byte (cmd 0 = byte, 1 = finish);
// rsp_ch returns memory writes (apply mode) and one report per finish command;
// csr_ch writes apply_mode (index 0) and table_length (index 1) and is always ready;
// the user must write them only while the block is idle; the block does not enforce this.
// Throughput: one request per cycle while req_ch.ready is high. Each request
// updates the parse state in the cycle it is accepted, and any result it causes
// lands in the output register, visible on rsp_ch in the following cycle.
// A byte that completes a pair in apply mode (outside version records) yields a
// write; a finish yields a report with status and info addresses, then clears
// the parse. Other bytes yield nothing.
// Stall: req_ch.ready is high while the output register is empty or being
// drained; with rsp_ch stalled and a result held, new requests wait.
// Reset clears the parse state, both registers and the output valid flag.
// depends on ptrs_pkg, ptrs_req_if, ptrs_rsp_if, ptrs_csr_if
`default_nettype none

module patch_table_record_streamer_unit #(
   parameter int TABLE_LEN_BITS = 20
) (
   input  wire           clock,
   input  wire           reset,
   ptrs_req_if.sink      req_ch,
   ptrs_rsp_if.source    rsp_ch,
   ptrs_csr_if.sink      csr_ch
);

   localparam int TL_W = TABLE_LEN_BITS;
   localparam int PL_W = TABLE_LEN_BITS - 2;
   localparam int HB_W = ptrs_pkg::HDR_BYTE_BITS;
   localparam int PN_W = ptrs_pkg::PAIR_NUM_BITS;
   localparam int PB_W = ptrs_pkg::PAIR_BYTE_BITS;

   // configuration
   logic            apply_mode_ff;
   logic [TL_W-1:0] table_length_ff;

   // parse state
   logic [TL_W-1:0]            byte_offset_ff,  byte_offset_in;
   ptrs_pkg::phase_type        parse_phase_ff,  parse_phase_in;
   logic                       tag_matches_ff,  tag_matches_in;
   logic [31:0]                word_buffer_ff,  word_buffer_in;
   ptrs_pkg::record_class_type record_class_ff, record_class_in;
   logic [PL_W-1:0]            pairs_left_ff,   pairs_left_in;
   logic [PN_W-1:0]            pair_number_ff,  pair_number_in;
   logic [PB_W-1:0]            pair_byte_ff,    pair_byte_in;
   logic [HB_W-1:0]            header_byte_ff,  header_byte_in;
   logic [31:0]                pair_address_ff, pair_address_in;
   logic                       seen_record_ff,  seen_record_in;
   logic                       seen_info_ff,    seen_info_in;
   logic [31:0]                first_info_ff,   first_info_in;
   logic [31:0]                second_info_ff,  second_info_in;
   logic                       error_ff,        error_in;

   // output register
   logic                 rsp_valid_ff;
   ptrs_pkg::result_type rsp_data_ff;

   logic                 in_fire;
   logic                 res_valid;
   ptrs_pkg::result_type res;

   logic [31:0]     wb_shift;
   logic [31:0]     count;
   logic [TL_W-1:0] rest;
   logic [TL_W-1:0] count_x8;
   logic            count_over;
   logic            finish_bad;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign in_fire      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.kind    = rsp_data_ff.kind;
   assign rsp_ch.address = rsp_data_ff.address;
   assign rsp_ch.value   = rsp_data_ff.value;
   assign rsp_ch.status  = rsp_data_ff.status;

   assign wb_shift = {req_ch.table_byte, word_buffer_ff[31:8]};
   assign count    = (record_class_ff == ptrs_pkg::CL_HIGH) ? 32'd0 : wb_shift;
   assign rest     = table_length_ff - byte_offset_ff - 1'b1;
   // count * 8 is truncated to the length width; any bit that shifts past it sets count_over
   assign count_x8   = {count[TL_W-4:0], 3'b000};
   assign count_over = (|count[31:TL_W-3]) || (count_x8 > rest);

   assign finish_bad = error_ff || !tag_matches_ff ||
                       (table_length_ff < TL_W'(ptrs_pkg::TAG_BYTES)) ||
                       (byte_offset_ff < table_length_ff) || !seen_record_ff ||
                       (!apply_mode_ff && !seen_info_ff);

   always_comb begin
      byte_offset_in  = byte_offset_ff;
      parse_phase_in  = parse_phase_ff;
      tag_matches_in  = tag_matches_ff;
      word_buffer_in  = word_buffer_ff;
      record_class_in = record_class_ff;
      pairs_left_in   = pairs_left_ff;
      pair_number_in  = pair_number_ff;
      pair_byte_in    = pair_byte_ff;
      header_byte_in  = header_byte_ff;
      pair_address_in = pair_address_ff;
      seen_record_in  = seen_record_ff;
      seen_info_in    = seen_info_ff;
      first_info_in   = first_info_ff;
      second_info_in  = second_info_ff;
      error_in        = error_ff;
      res_valid       = 1'b0;
      res.kind        = ptrs_pkg::KIND_WRITE;
      res.address     = pair_address_ff;
      res.value       = wb_shift;
      res.status      = ptrs_pkg::STATUS_OK;

      if (in_fire && req_ch.cmd == ptrs_pkg::CMD_FINISH) begin
         res_valid       = 1'b1;
         res.kind        = ptrs_pkg::KIND_FINISH;
         res.address     = first_info_ff;
         res.value       = second_info_ff;
         res.status      = finish_bad ? ptrs_pkg::STATUS_BAD : ptrs_pkg::STATUS_OK;
         byte_offset_in  = '0;
         parse_phase_in  = ptrs_pkg::PH_TAG;
         tag_matches_in  = 1'b1;
         word_buffer_in  = '0;
         record_class_in = ptrs_pkg::CL_PLAIN;
         pairs_left_in   = '0;
         pair_number_in  = '0;
         pair_byte_in    = '0;
         header_byte_in  = '0;
         pair_address_in = '0;
         seen_record_in  = 1'b0;
         seen_info_in    = 1'b0;
         first_info_in   = '0;
         second_info_in  = '0;
         error_in        = 1'b0;
      end else if (in_fire && !error_ff && (byte_offset_ff < table_length_ff)) begin
         byte_offset_in = byte_offset_ff + 1'b1;
         case (parse_phase_ff)
            ptrs_pkg::PH_TAG: begin
               if (byte_offset_ff < TL_W'(ptrs_pkg::TAG_CHECKED) &&
                   req_ch.table_byte != ptrs_pkg::tag_char(byte_offset_ff[3:0])) begin
                  tag_matches_in = 1'b0;
               end
               if (byte_offset_ff == TL_W'(ptrs_pkg::TAG_BYTES - 1)) begin
                  if (!tag_matches_in) begin
                     error_in = 1'b1;
                  end
                  parse_phase_in = ptrs_pkg::PH_HEADER;
                  header_byte_in = '0;
               end
            end
            ptrs_pkg::PH_HEADER: begin
               if (header_byte_ff == '0 && (table_length_ff - byte_offset_ff) <
                   TL_W'(ptrs_pkg::HEADER_BYTES)) begin
                  error_in = 1'b1;
               end else begin
                  word_buffer_in = wb_shift;
                  if (header_byte_ff == HB_W'(ptrs_pkg::HDR_TYPE_LAST)) begin
                     if (wb_shift == ptrs_pkg::TYPE_INFO) begin
                        record_class_in = seen_info_ff ? ptrs_pkg::CL_INFO_LATER
                                                       : ptrs_pkg::CL_INFO_FIRST;
                     end else if (wb_shift == ptrs_pkg::TYPE_MODE) begin
                        record_class_in = ptrs_pkg::CL_MODE;
                     end else if (wb_shift == ptrs_pkg::TYPE_VERSION) begin
                        record_class_in = ptrs_pkg::CL_VERSION;
                     end else if (wb_shift >= ptrs_pkg::TYPE_NO_PAIRS) begin
                        record_class_in = ptrs_pkg::CL_HIGH;
                     end else begin
                        record_class_in = ptrs_pkg::CL_PLAIN;
                     end
                  end
                  if (header_byte_ff == HB_W'(ptrs_pkg::HEADER_BYTES - 1)) begin
                     header_byte_in = '0;
                     seen_record_in = 1'b1;
                     if (count_over) begin
                        error_in = 1'b1;
                     end else if ((record_class_ff == ptrs_pkg::CL_INFO_FIRST ||
                                   record_class_ff == ptrs_pkg::CL_INFO_LATER) &&
                                  count < 32'(ptrs_pkg::INFO_PAIRS)) begin
                        error_in = 1'b1;
                     end else if (apply_mode_ff && record_class_ff == ptrs_pkg::CL_MODE &&
                                  count < 32'(ptrs_pkg::MODE_PAIRS)) begin
                        error_in = 1'b1;
                     end else begin
                        if (record_class_ff == ptrs_pkg::CL_INFO_FIRST) begin
                           seen_info_in = 1'b1;
                        end
                        // fit check bounds count well inside the counter width
                        pairs_left_in  = count[PL_W-1:0];
                        pair_number_in = '0;
                        pair_byte_in   = '0;
                        parse_phase_in = (count != 32'd0) ? ptrs_pkg::PH_PAIRS
                                                          : ptrs_pkg::PH_HEADER;
                     end
                  end else begin
                     header_byte_in = header_byte_ff + 1'b1;
                  end
               end
            end
            ptrs_pkg::PH_PAIRS: begin
               word_buffer_in = wb_shift;
               if (pair_byte_ff == PB_W'(ptrs_pkg::PAIR_ADDR_LAST)) begin
                  pair_address_in = wb_shift;
               end
               if (pair_byte_ff == PB_W'(ptrs_pkg::PAIR_LAST)) begin
                  if (record_class_ff == ptrs_pkg::CL_INFO_FIRST) begin
                     if (pair_number_ff == PN_W'(0)) first_info_in  = wb_shift;
                     if (pair_number_ff == PN_W'(1)) second_info_in = wb_shift;
                  end
                  if (apply_mode_ff && record_class_ff != ptrs_pkg::CL_VERSION) begin
                     res_valid = 1'b1;
                     if (record_class_ff == ptrs_pkg::CL_MODE &&
                         pair_number_ff < PN_W'(ptrs_pkg::MODE_PAIRS)) begin
                        res.value = ptrs_pkg::mode_value(pair_number_ff);
                     end
                  end
                  if (pair_number_ff < PN_W'(ptrs_pkg::MODE_PAIRS)) begin
                     pair_number_in = pair_number_ff + 1'b1;
                  end
                  pair_byte_in  = '0;
                  pairs_left_in = pairs_left_ff - 1'b1;
                  if (pairs_left_in == '0) begin
                     parse_phase_in = ptrs_pkg::PH_HEADER;
                  end
               end else begin
                  pair_byte_in = pair_byte_ff + 1'b1;
               end
            end
            default: begin
               parse_phase_in = ptrs_pkg::PH_TAG;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         apply_mode_ff   <= 1'b0;
         table_length_ff <= '0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            ptrs_pkg::CSR_APPLY_MODE:   apply_mode_ff   <= csr_ch.data[0];
            ptrs_pkg::CSR_TABLE_LENGTH: table_length_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff  <= '0;
         parse_phase_ff  <= ptrs_pkg::PH_TAG;
         tag_matches_ff  <= 1'b1;
         word_buffer_ff  <= '0;
         record_class_ff <= ptrs_pkg::CL_PLAIN;
         pairs_left_ff   <= '0;
         pair_number_ff  <= '0;
         pair_byte_ff    <= '0;
         header_byte_ff  <= '0;
         pair_address_ff <= '0;
         seen_record_ff  <= 1'b0;
         seen_info_ff    <= 1'b0;
         first_info_ff   <= '0;
         second_info_ff  <= '0;
         error_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         byte_offset_ff  <= byte_offset_in;
         parse_phase_ff  <= parse_phase_in;
         tag_matches_ff  <= tag_matches_in;
         word_buffer_ff  <= word_buffer_in;
         record_class_ff <= record_class_in;
         pairs_left_ff   <= pairs_left_in;
         pair_number_ff  <= pair_number_in;
         pair_byte_ff    <= pair_byte_in;
         header_byte_ff  <= header_byte_in;
         pair_address_ff <= pair_address_in;
         seen_record_ff  <= seen_record_in;
         seen_info_ff    <= seen_info_in;
         first_info_ff   <= first_info_in;
         second_info_ff  <= second_info_in;
         error_ff        <= error_in;
         if (res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   // a result only appears after an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_fire))
      else $error("result appeared without an accepted transaction");

   // memory writes never carry a bad status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.kind == ptrs_pkg::KIND_WRITE) |->
         rsp_data_ff.status == ptrs_pkg::STATUS_OK)
      else $error("memory write with bad status");

   // a latched error holds until a finish clears the parse
   assert property (@(posedge clock) disable iff (reset)
      (error_ff && !(in_fire && req_ch.cmd == ptrs_pkg::CMD_FINISH)) |=> error_ff)
      else $error("error flag dropped without finish");

   // no write is produced once an error is latched
   assert property (@(posedge clock) disable iff (reset)
      (error_ff && in_fire && req_ch.cmd == ptrs_pkg::CMD_BYTE) |=>
         !(rsp_valid_ff && rsp_data_ff.kind == ptrs_pkg::KIND_WRITE &&
           $past(res_valid)))
      else $error("write emitted after error");

endmodule

`default_nettype wire
